FILE: rtl/skf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // gain is always Q1.16, independent of the value format
    localparam int          GAIN_BITS = 16;
    localparam int          GAIN_W    = GAIN_BITS + 1;
    localparam logic [16:0] GAIN_ONE  = 17'h10000;

    // divider: {P, 16 zeros} + den/2 over den = P + R
    localparam int NUM_W = 49;
    localparam int DEN_W = 33;
    localparam int QUO_W = 17;
    localparam int CNT_W = 5;

    localparam int APB_AW = 4;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_PREDICT = 2'd2;
    localparam logic [1:0] CMD_UPDATE  = 2'd3;

    localparam logic [1:0] REG_MEAS_NOISE = 2'd0;
    localparam logic [1:0] REG_PROC_NOISE = 2'd1;
    localparam logic [1:0] REG_INIT_ERR   = 2'd2;

    localparam logic [31:0] MEAS_NOISE_RST = 32'd65536;
    localparam logic [31:0] PROC_NOISE_RST = 32'd655;
    localparam logic [31:0] INIT_ERR_RST   = 32'd65536;

    // microcode addresses
    localparam int             PC_W          = 4;
    localparam logic [PC_W-1:0] PC_INIT      = 4'd0;
    localparam logic [PC_W-1:0] PC_INIT_LOAD = 4'd1;
    localparam logic [PC_W-1:0] PC_INIT_BAD  = 4'd2;
    localparam logic [PC_W-1:0] PC_RESET     = 4'd3;
    localparam logic [PC_W-1:0] PC_PREDICT   = 4'd4;
    localparam logic [PC_W-1:0] PC_PRED_APPLY = 4'd5;
    localparam logic [PC_W-1:0] PC_UPDATE    = 4'd6;
    localparam logic [PC_W-1:0] PC_DIV_WAIT  = 4'd7;
    localparam logic [PC_W-1:0] PC_GAIN      = 4'd8;
    localparam logic [PC_W-1:0] PC_CORR      = 4'd9;
    localparam logic [PC_W-1:0] PC_EST_UPD   = 4'd10;
    localparam logic [PC_W-1:0] PC_COV_UPD   = 4'd11;
    localparam logic [PC_W-1:0] PC_DONE      = 4'd12;

    typedef enum logic [1:0] {MUL_NONE, MUL_PRED, MUL_CORR, MUL_COV} t_mul;
    typedef enum logic [1:0] {EST_HOLD, EST_LOAD, EST_ADD_F, EST_ADD_G} t_est_op;
    typedef enum logic [1:0] {COV_HOLD, COV_INIT, COV_ADD_Q, COV_SHRINK} t_cov_op;
    typedef enum logic [1:0] {GAIN_HOLD, GAIN_CLEAR, GAIN_DIV} t_gain_op;
    typedef enum logic [1:0] {JC_NEXT, JC_GOTO, JC_CFG_BAD, JC_DIV_BUSY} t_jc;

    typedef struct packed {
        t_mul             mul;
        t_est_op          est;
        t_cov_op          cov;
        t_gain_op         gain;
        logic             div_start;
        logic             set_status;
        logic             done;
        t_jc              jc;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mul: MUL_NONE, est: EST_HOLD, cov: COV_HOLD, gain: GAIN_HOLD,
        div_start: 1'b0, set_status: 1'b0, done: 1'b0,
        jc: JC_NEXT, target: PC_INIT
    };

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic signed [31:0] control;
        logic [31:0]        dt;
        logic [31:0]        snoise;
        logic               use_snoise;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [31:0] meas_noise;
        logic [31:0] proc_noise;
        logic [31:0] init_err;
    } t_cfg;

    typedef struct packed {
        logic cfg_bad;
        logic div_busy;
        logic out_free;
    } t_cond;

    function automatic logic [PC_W-1:0] ucode_entry(input logic [1:0] cmd);
        logic [PC_W-1:0] pc;
        unique case (cmd)
            CMD_INIT:    pc = PC_INIT;
            CMD_RESET:   pc = PC_RESET;
            CMD_PREDICT: pc = PC_PREDICT;
            CMD_UPDATE:  pc = PC_UPDATE;
            default:     pc = PC_INIT;
        endcase
        return pc;
    endfunction

    // control store
    function automatic t_uword ucode_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            PC_INIT: begin
                w.jc     = JC_CFG_BAD;
                w.target = PC_INIT_BAD;
            end
            PC_INIT_LOAD: begin
                w.est    = EST_LOAD;
                w.cov    = COV_INIT;
                w.gain   = GAIN_CLEAR;
                w.jc     = JC_GOTO;
                w.target = PC_DONE;
            end
            PC_INIT_BAD: begin
                w.set_status = 1'b1;
                w.jc         = JC_GOTO;
                w.target     = PC_DONE;
            end
            PC_RESET: begin
                w.est    = EST_LOAD;
                w.gain   = GAIN_CLEAR;
                w.jc     = JC_GOTO;
                w.target = PC_DONE;
            end
            PC_PREDICT: begin
                w.mul = MUL_PRED;
            end
            PC_PRED_APPLY: begin
                w.est    = EST_ADD_F;
                w.cov    = COV_ADD_Q;
                w.jc     = JC_GOTO;
                w.target = PC_DONE;
            end
            PC_UPDATE: begin
                w.div_start = 1'b1;
            end
            PC_DIV_WAIT: begin
                w.jc     = JC_DIV_BUSY;
                w.target = PC_DIV_WAIT;
            end
            PC_GAIN: begin
                w.gain = GAIN_DIV;
            end
            PC_CORR: begin
                w.mul = MUL_CORR;
            end
            PC_EST_UPD: begin
                w.est = EST_ADD_G;
                w.mul = MUL_COV;
            end
            PC_COV_UPD: begin
                w.cov = COV_SHRINK;
            end
            PC_DONE: begin
                w.done = 1'b1;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/skf_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [1:0]             i_cmd,
    input  skf_pkg::t_cond        i_cond,
    output skf_pkg::t_uword       o_uword,
    output logic                  o_busy
);
    import skf_pkg::*;

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_rom;

    assign w_rom   = ucode_word(r_pc);
    assign o_uword = r_busy ? w_rom : UW_NOP;
    assign o_busy  = r_busy;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = ucode_entry(i_cmd);
            end
        end else if (w_rom.done) begin
            // hold on the final step until the output register is free
            if (i_cond.out_free) begin
                n_busy = 1'b0;
            end
        end else begin
            unique case (w_rom.jc)
                JC_NEXT:     n_pc = r_pc + 1'b1;
                JC_GOTO:     n_pc = w_rom.target;
                JC_CFG_BAD:  n_pc = i_cond.cfg_bad ? w_rom.target : r_pc + 1'b1;
                JC_DIV_BUSY: n_pc = i_cond.div_busy ? w_rom.target : r_pc + 1'b1;
                default:     n_pc = r_pc + 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_INIT;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/skf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [skf_pkg::NUM_W-1:0]     i_num,
    input  wire [skf_pkg::DEN_W-1:0]     i_den,
    output logic                         o_busy,
    output logic [skf_pkg::QUO_W-1:0]    o_quot
);
    import skf_pkg::*;

    // restoring divider, one quotient bit per cycle; quotient must fit QUO_W
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_low, n_low;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_low[QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_rem = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
        n_low = {r_low[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[NUM_W-1:QUO_W]};
            r_low <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_low;

endmodule

`default_nettype wire

FILE: rtl/skf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module skf_dp #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  skf_pkg::t_uword              i_uword,
    input  skf_pkg::t_item               i_item,
    input  skf_pkg::t_cfg                i_cfg,
    input  wire [skf_pkg::QUO_W-1:0]     i_quot,
    output logic                         o_div_start,
    output logic [skf_pkg::NUM_W-1:0]    o_div_num,
    output logic [skf_pkg::DEN_W-1:0]    o_div_den,
    output logic signed [31:0]           o_est,
    output logic [skf_pkg::GAIN_W-1:0]   o_gain,
    output logic [31:0]                  o_cov
);
    import skf_pkg::*;

    localparam logic [64:0] HALF_F = 65'(1) << (FRAC_BITS - 1);
    localparam logic [64:0] HALF_G = 65'(1) << (GAIN_BITS - 1);

    logic signed [31:0] r_est;
    logic [31:0]        r_cov;
    logic [GAIN_W-1:0]  r_gain;
    logic signed [63:0] r_prod;
    logic signed [32:0] r_innov;
    logic               r_den_zero;

    logic [31:0]        w_noise;
    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_mul_p;
    logic signed [64:0] w_rnd_f, w_rnd_g;
    logic signed [65:0] w_sum_f, w_sum_g;
    logic [32:0]        w_cov_q;
    logic [47:0]        w_cov_s;
    logic [GAIN_W-1:0]  w_gain_div;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if ((v[65:31] == '0) || (v[65:31] == '1)) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    // divider operands: P*2^16 + (P+R)/2 over P+R
    assign w_noise     = i_item.use_snoise ? i_item.snoise : i_cfg.meas_noise;
    assign o_div_den   = {1'b0, r_cov} + {1'b0, w_noise};
    assign o_div_num   = {1'b0, r_cov, 16'h0000} + {17'h0_0000, o_div_den[DEN_W-1:1]};
    assign o_div_start = i_uword.div_start;

    // shared multiplier
    always_comb begin
        unique case (i_uword.mul)
            MUL_PRED: begin
                w_mul_a = {i_item.control[31], i_item.control};
                w_mul_b = {1'b0, i_item.dt};
            end
            MUL_CORR: begin
                w_mul_a = {16'h0000, r_gain};
                w_mul_b = r_innov;
            end
            MUL_COV: begin
                w_mul_a = {16'h0000, GAIN_ONE - r_gain};
                w_mul_b = {1'b0, r_cov};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // round half up, then saturating add to the estimate
    assign w_rnd_f = ($signed({r_prod[63], r_prod}) + $signed(HALF_F)) >>> FRAC_BITS;
    assign w_rnd_g = ($signed({r_prod[63], r_prod}) + $signed(HALF_G)) >>> GAIN_BITS;
    assign w_sum_f = {{34{r_est[31]}}, r_est} + {w_rnd_f[64], w_rnd_f};
    assign w_sum_g = {{34{r_est[31]}}, r_est} + {w_rnd_g[64], w_rnd_g};

    assign w_cov_q = {1'b0, r_cov} + {1'b0, i_cfg.proc_noise};
    assign w_cov_s = r_prod[47:0] + 48'(HALF_G);

    assign w_gain_div = (r_den_zero || (i_quot > GAIN_ONE)) ? GAIN_ONE : i_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est  <= '0;
            r_cov  <= '0;
            r_gain <= '0;
        end else begin
            unique case (i_uword.est)
                EST_LOAD:  r_est <= i_item.value;
                EST_ADD_F: r_est <= sat32(w_sum_f);
                EST_ADD_G: r_est <= sat32(w_sum_g);
                default:   r_est <= r_est;
            endcase
            unique case (i_uword.cov)
                COV_INIT:   r_cov <= i_cfg.init_err;
                COV_ADD_Q:  r_cov <= w_cov_q[32] ? 32'hffff_ffff : w_cov_q[31:0];
                COV_SHRINK: r_cov <= w_cov_s[47:16];
                default:    r_cov <= r_cov;
            endcase
            unique case (i_uword.gain)
                GAIN_CLEAR: r_gain <= '0;
                GAIN_DIV:   r_gain <= w_gain_div;
                default:    r_gain <= r_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.mul != MUL_NONE) begin
            r_prod <= w_mul_p[63:0];
        end
        if (i_uword.div_start) begin
            r_innov    <= {i_item.value[31], i_item.value} - {r_est[31], r_est};
            r_den_zero <= (o_div_den == '0);
        end
    end

    assign o_est  = r_est;
    assign o_gain = r_gain;
    assign o_cov  = r_cov;

endmodule

`default_nettype wire

FILE: rtl/scalar_kalman_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Scalar Kalman filter, fixed point (values Q(32-F).F, gain Q1.16). Each
// input word carries one command in tuser (init, reset estimate, predict,
// update) and yields exactly one output word with the estimate, gain and
// covariance after the step plus status flags. The block works on one word
// at a time under a small microcoded sequencer; s_axis_tready is high
// while it is idle. Update takes longest, its time being set by the
// restoring divider for the gain and its wait step. The next word is
// accepted the cycle after its result enters the output register, even
// if m_axis is still stalled. Configuration (APB, byte addresses 0x0
// measurement noise, 0x4 process noise, 0x8 initial error) must be
// written only while the block is idle.

module scalar_kalman_filter #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input stream
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [31:0] value, [63:32] control rate, [95:64] time_step,
    // [127:96] sensor_noise
    input  wire [127:0]                  s_axis_tdata,
    // [1:0] command, [2] use_sensor_noise
    input  wire [2:0]                    s_axis_tuser,
    input  wire                          s_axis_tlast,   // last_reading
    // output stream
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [31:0] estimate_out, [48:32] gain_out, [80:49] covariance_out,
    // [87:81] zero
    output logic [87:0]                  m_axis_tdata,
    // [0] status, [1] config_valid
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast,   // fused_done
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [skf_pkg::APB_AW-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import skf_pkg::*;

    logic        r_m_valid;
    logic [87:0] r_m_data;
    logic [1:0]  r_m_user;
    logic        r_m_last;

    t_cfg        r_cfg;
    t_item       r_item;
    logic        r_status;

    t_uword      w_uword;
    t_cond       w_cond;
    logic        w_busy;
    logic        w_accept;
    logic        w_publish;
    logic        w_cfg_wr;

    logic                 w_div_start;
    logic [NUM_W-1:0]     w_div_num;
    logic [DEN_W-1:0]     w_div_den;
    logic                 w_div_busy;
    logic [QUO_W-1:0]     w_quot;
    logic signed [31:0]   w_est;
    logic [GAIN_W-1:0]    w_gain;
    logic [31:0]          w_cov;

    assign s_axis_tready = !w_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- configuration registers ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.meas_noise <= MEAS_NOISE_RST;
            r_cfg.proc_noise <= PROC_NOISE_RST;
            r_cfg.init_err   <= INIT_ERR_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_MEAS_NOISE: r_cfg.meas_noise <= pwdata;
                REG_PROC_NOISE: r_cfg.proc_noise <= pwdata;
                REG_INIT_ERR:   r_cfg.init_err   <= pwdata;
                default: ;  // unmapped word, ignored
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MEAS_NOISE: prdata = r_cfg.meas_noise;
            REG_PROC_NOISE: prdata = r_cfg.proc_noise;
            REG_INIT_ERR:   prdata = r_cfg.init_err;
            default:        prdata = '0;
        endcase
    end

    // ---------------- input word capture ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd        <= s_axis_tuser[1:0];
            r_item.value      <= s_axis_tdata[31:0];
            r_item.control    <= s_axis_tdata[63:32];
            r_item.dt         <= s_axis_tdata[95:64];
            r_item.snoise     <= s_axis_tdata[127:96];
            r_item.use_snoise <= s_axis_tuser[2];
            r_item.last       <= s_axis_tlast;
        end
    end

    // status is set only when init is rejected by the microcode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= 1'b0;
        end else if (w_accept) begin
            r_status <= 1'b0;
        end else if (w_uword.set_status) begin
            r_status <= 1'b1;
        end
    end

    // ---------------- sequencer, datapath, divider ----------------
    assign w_cond.cfg_bad  = (r_cfg.init_err == '0) || (r_cfg.meas_noise == '0);
    assign w_cond.div_busy = w_div_busy;
    assign w_cond.out_free = !r_m_valid || m_axis_tready;

    skf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_cmd   (s_axis_tuser[1:0]),
        .i_cond  (w_cond),
        .o_uword (w_uword),
        .o_busy  (w_busy)
    );

    skf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .i_quot      (w_quot),
        .o_div_start (w_div_start),
        .o_div_num   (w_div_num),
        .o_div_den   (w_div_den),
        .o_est       (w_est),
        .o_gain      (w_gain),
        .o_cov       (w_cov)
    );

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // ---------------- output register ----------------
    // the final microstep copies the settled state into the output word
    assign w_publish = w_uword.done && w_cond.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_publish) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_publish) begin
            r_m_data <= {7'h00, w_cov, w_gain, w_est};
            r_m_user <= {(r_cfg.meas_noise != '0), r_status};
            r_m_last <= r_item.last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

FILE: test/tb_scalar_kalman_filter.sv
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
    import skf_pkg::*;

    localparam int     FRAC     = FRAC_BITS_DEF;
    localparam longint U32_MAX  = 64'h0000_0000_FFFF_FFFF;
    localparam longint S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN  = -64'sh0000_0000_8000_0000;
    localparam longint UNITY    = 64'sd1 << GAIN_BITS;

    // one output word, unpacked
    typedef struct packed {
        logic signed [31:0] est;
        logic [GAIN_W-1:0]  gain;
        logic [31:0]        cov;
        logic               status;
        logic               cfg_ok;
        logic               fused;
    } t_filt_out;

    // Filter state tracker: mirrors the registers and the estimate/gain/
    // covariance, and queues the state expected after each accepted word.
    class t_kalman_tracker;
        logic [31:0]        meas_r = MEAS_NOISE_RST;
        logic [31:0]        proc_q = PROC_NOISE_RST;
        logic [31:0]        init_p = INIT_ERR_RST;
        logic signed [31:0] est    = '0;
        logic [31:0]        cov    = '0;
        logic [GAIN_W-1:0]  gain   = '0;
        t_filt_out          future_states[$];
        int                 mismatches = 0;

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_MEAS_NOISE: meas_r = val;
                REG_PROC_NOISE: proc_q = val;
                REG_INIT_ERR:   init_p = val;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > S32_MAX) return S32_MAX[31:0];
            if (v < S32_MIN) return S32_MIN[31:0];
            return v[31:0];
        endfunction

        function void take_command(t_item w);
            t_filt_out r;
            longint    prod, delta, sum, p, den, g, innov, corr;
            logic      rejected;
            rejected = 1'b0;
            case (w.cmd)
                CMD_INIT: begin
                    // bad noise registers: state untouched, flag it
                    if (init_p == 0 || meas_r == 0) begin
                        rejected = 1'b1;
                    end else begin
                        est  = w.value;
                        cov  = init_p;
                        gain = '0;
                    end
                end
                CMD_RESET: begin
                    est  = w.value;
                    gain = '0;
                end
                CMD_PREDICT: begin
                    prod  = longint'($signed(w.control)) * longint'(w.dt);
                    delta = (prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
                    est   = clamp32(longint'(est) + delta);
                    sum   = longint'(cov) + longint'(proc_q);
                    cov   = (sum > U32_MAX) ? 32'hFFFF_FFFF : sum[31:0];
                end
                default: begin
                    p   = longint'(cov);
                    den = p + longint'(w.use_snoise ? w.snoise : meas_r);
                    // P + R == 0 means full trust in the reading
                    if (den == 0) g = UNITY;
                    else          g = ((p <<< GAIN_BITS) + (den >>> 1)) / den;
                    if (g > UNITY) g = UNITY;
                    gain  = g[GAIN_W-1:0];
                    innov = longint'($signed(w.value)) - longint'(est);
                    corr  = (g * innov + (UNITY >>> 1)) >>> GAIN_BITS;
                    est   = clamp32(longint'(est) + corr);
                    sum   = ((UNITY - g) * p + (UNITY >>> 1)) >>> GAIN_BITS;
                    cov   = sum[31:0];
                end
            endcase
            r.est    = est;
            r.gain   = gain;
            r.cov    = cov;
            r.status = rejected;
            r.cfg_ok = (meas_r != 0);
            r.fused  = w.last;
            future_states.push_back(r);
        endfunction

        function void diff(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void match_output(t_filt_out seen);
            t_filt_out want;
            if (future_states.size() == 0) begin
                $error("output word with no command outstanding");
                mismatches++;
                return;
            end
            want = future_states.pop_front();
            diff("estimate_out", longint'(want.est), longint'(seen.est));
            diff("gain_out", longint'(want.gain), longint'(seen.gain));
            diff("covariance_out", longint'(want.cov), longint'(seen.cov));
            diff("status", longint'(want.status), longint'(seen.status));
            diff("config_valid", longint'(want.cfg_ok), longint'(seen.cfg_ok));
            diff("fused_done", longint'(want.fused), longint'(seen.fused));
        endfunction

        function int outstanding();
            return future_states.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [127:0]        s_axis_tdata;   // value, control rate, time_step, sensor_noise
    logic [2:0]          s_axis_tuser;   // command[1:0], use_sensor_noise
    logic                s_axis_tlast;   // last_reading
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [87:0]         m_axis_tdata;   // estimate_out, gain_out, covariance_out, zero pad
    logic [1:0]          m_axis_tuser;   // status, config_valid
    logic                m_axis_tlast;   // fused_done
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    t_kalman_tracker tracker = new();

    // idle odds in percent, per side
    int snd_idle = 29;
    int rcv_idle = 54;

    // long receiver hold-off, requested once by the stimulus
    logic hold_go    = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    always #1 i_clk = ~i_clk;

    scalar_kalman_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Output side: random back-pressure, plus one long hold-off so the
    // block fills and stops taking words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        t_filt_out seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.est    = m_axis_tdata[31:0];
            seen.gain   = m_axis_tdata[48:32];
            seen.cov    = m_axis_tdata[80:49];
            seen.status = m_axis_tuser[0];
            seen.cfg_ok = m_axis_tuser[1];
            seen.fused  = m_axis_tlast;
            tracker.match_output(seen);
        end
    end

    // log-spread magnitudes so every bit toggles, with the odd extreme
    function automatic logic [31:0] span_u();
        logic [31:0] r;
        r = $urandom();
        if ($urandom_range(15) == 0)
            return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        return r >> $urandom_range(31);
    endfunction

    function automatic logic [31:0] span_s();
        logic signed [31:0] r;
        r = $urandom();
        if ($urandom_range(15) == 0)
            return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return r >>> $urandom_range(31);
    endfunction

    // Offer one word, idling first as the sender's odds say; returns at
    // the edge where it is taken.
    task automatic push_word(input t_item w);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.snoise, w.dt, w.control, w.value};
        s_axis_tuser  <= {w.use_snoise, w.cmd};
        s_axis_tlast  <= w.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_command(w);
    endtask

    task automatic issue(input logic [1:0] cmd, input logic [31:0] value,
                         input logic [31:0] control, input logic [31:0] dt,
                         input logic [31:0] snoise, input logic use_s,
                         input logic last);
        t_item w;
        w.cmd        = cmd;
        w.value      = value;
        w.control    = control;
        w.dt         = dt;
        w.snoise     = snoise;
        w.use_snoise = use_s;
        w.last       = last;
        push_word(w);
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // APB write: setup then access; register lands when pready is seen
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: init/reset now and then, predicts, and
    // fused groups of updates closed by last_reading; some raw noise.
    task automatic run_random(input int count);
        t_item w;
        int    n;
        int    pick;
        int    grp;
        n = 0;
        while (n < count) begin
            w.value      = span_s();
            w.control    = $urandom();
            w.dt         = $urandom();
            w.snoise     = $urandom();
            w.use_snoise = 1'($urandom_range(1));
            w.last       = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 8) begin
                w.cmd = CMD_INIT;
                push_word(w);
                n++;
            end else if (pick < 13) begin
                w.cmd = CMD_RESET;
                push_word(w);
                n++;
            end else if (pick < 50) begin
                w.cmd     = CMD_PREDICT;
                w.control = span_s();
                w.dt      = ($urandom_range(7) == 0) ? span_u()
                                                    : $urandom() >> $urandom_range(12, 31);
                push_word(w);
                n++;
            end else if (pick < 90) begin
                grp = $urandom_range(1, 4);
                for (int j = 0; j < grp; j++) begin
                    w.cmd        = CMD_UPDATE;
                    w.value      = span_s();
                    w.snoise     = span_u();
                    w.use_snoise = ($urandom_range(3) != 0);
                    w.last       = (j == grp - 1);
                    w.control    = $urandom();
                    w.dt         = $urandom();
                    push_word(w);
                    n++;
                end
            end else begin
                w.cmd = 2'($urandom_range(3));
                push_word(w);
                n++;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] mn, input logic [31:0] pn,
                             input logic [31:0] ie, input int snd_pct,
                             input int rcv_pct, input int count,
                             input logic with_hold);
        drain();
        write_reg(REG_MEAS_NOISE, mn);
        write_reg(REG_PROC_NOISE, pn);
        write_reg(REG_INIT_ERR, ie);
        snd_idle = snd_pct;
        rcv_idle = rcv_pct;
        if (with_hold) hold_go <= 1'b1;
        run_random(count);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: update before any init, P = 0 and R from the register
        issue(CMD_UPDATE, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        // P + R = 0: gain goes to one, estimate snaps to the reading
        issue(CMD_UPDATE, 32'hFFFD_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        // saturate the estimate both ways through predict
        issue(CMD_INIT, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        issue(CMD_PREDICT, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        issue(CMD_RESET, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        issue(CMD_PREDICT, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        issue(CMD_PREDICT, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        // rounding of the predict step at exact halves and just past them
        issue(CMD_RESET, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        issue(CMD_PREDICT, 32'h0, 32'h1, 32'h0000_8000, 32'h0, 1'b0, 1'b0);
        issue(CMD_PREDICT, 32'h0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0, 1'b0, 1'b0);
        issue(CMD_PREDICT, 32'h0, 32'hFFFF_FFFF, 32'h0000_8001, 32'h0, 1'b0, 1'b0);
        // updates at the field extremes
        issue(CMD_INIT, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
        issue(CMD_UPDATE, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        issue(CMD_UPDATE, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        // fused group of three readings, each with its own noise
        issue(CMD_UPDATE, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0);
        issue(CMD_UPDATE, 32'h0002_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b1, 1'b0);
        issue(CMD_UPDATE, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
        // unused fields all ones
        issue(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
        issue(CMD_PREDICT, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        issue(CMD_INIT, 32'h0004_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

        // register settings; zero noise registers make init get rejected
        run_phase(32'd65536, 32'd655, 32'd65536, 29, 54, 220, 1'b0);
        run_phase(32'd1, 32'd0, 32'd1, 29, 54, 220, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 54, 29, 220, 1'b1);
        run_phase(32'd0, 32'd655, 32'd65536, 54, 29, 120, 1'b0);
        run_phase(32'd65536, 32'd1000, 32'd0, 0, 0, 120, 1'b0);
        run_phase(span_u() | 32'h1, span_u(), span_u() | 32'h1, 0, 0, 450, 1'b0);

        drain();
        // update path is the longest
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/skf_pkg.sv
rtl/skf_seq.sv
rtl/skf_div.sv
rtl/skf_dp.sv
rtl/scalar_kalman_filter.sv
test/tb_scalar_kalman_filter.sv
